>>> design/lifu_pkg.sv
// Shared types, constants and command codes for the LIF neuron event update unit.
package lifu_pkg;

  localparam int NEURONS_DEF      = 256;
  localparam int MAX_SYNAPSES_DEF = 16;
  localparam logic [31:0] LEAK_RESET = 32'h0001_0000;

  localparam int IN_DATA_W  = 128;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 72;

  typedef enum logic [1:0] {
    CMD_SPIKE    = 2'd0,
    CMD_LOAD_THR = 2'd1,
    CMD_LOAD_CNT = 2'd2,
    CMD_LOAD_SYN = 2'd3
  } cmd_t;

  typedef struct packed {
    logic        last;
    logic [31:0] time_tk;
    logic [31:0] charge;
    logic [7:0]  target;
  } spike_t;

endpackage

>>> design/lif_neuron_event_update_unit.sv
// Top level of the event-driven leaky integrate-and-fire neuron update unit.
// Input beats on s_axis: tuser carries the command (spike event or a table load),
// tdata the neuron, slot, time, value and synapse fields. Loads finish in the beat
// cycle. A spike event reads the neuron state, multiplies elapsed ticks by the
// decay rate in the shared multiplier, clamps, adds with saturation and compares
// against the threshold, then returns to idle when it does not fire.
// On a firing, each stored synapse goes through a table read, a shared multiply of
// threshold by weight and a hand-off to the output register; m_axis carries one
// spike per beat, tlast on the final spike of a firing. The first spike beat is
// valid once the output register loads it from the hand-off step. A stalled
// receiver holds the output register and the sequencer waits in its hand-off
// step. After rst the unit clears charge, last update time and synapse counts,
// one neuron per cycle, with s_axis_tready low until all neurons are cleared;
// the decay rate register returns to 1.0 per tick and may be written through
// cfg_wr_en / cfg_wr_data at any time the unit is idle.
module lif_neuron_event_update_unit #(
  parameter int NEURONS      = lifu_pkg::NEURONS_DEF,
  parameter int MAX_SYNAPSES = lifu_pkg::MAX_SYNAPSES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [31:0]                       cfg_wr_data,   // charge lost per tick, Q16.16
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // neuron[7:0] slot[11:8] event_time[43:12] value[75:44] syn_target[83:76]
  // syn_weight[99:84] syn_delay[115:100] syn_count[120:116], zero fill above
  input  logic [lifu_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input  logic [lifu_pkg::IN_USER_W-1:0]    s_axis_tuser,  // cmd[1:0]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // spike_target[7:0] spike_charge[39:8] spike_time[71:40]
  output logic [lifu_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast   // last
);
  import lifu_pkg::*;

  localparam int NIW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int SIW = (MAX_SYNAPSES > 1) ? $clog2(MAX_SYNAPSES) : 1;
  localparam int CW  = $clog2(MAX_SYNAPSES + 1);
  localparam int SYN_DEPTH = NEURONS * (2 ** SIW);

  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_MUL   = 9'b000000100,
    ST_DECAY = 9'b000001000,
    ST_ADD   = 9'b000010000,
    ST_CMP   = 9'b000100000,
    ST_SRD   = 9'b001000000,
    ST_SMUL  = 9'b010000000,
    ST_SOUT  = 9'b100000000
  } state_t;

  // input fields
  cmd_t        in_cmd;
  logic [7:0]  in_neuron;
  logic [3:0]  in_slot;
  logic [31:0] in_time;
  logic [31:0] in_value;
  logic [7:0]  in_syn_target;
  logic [15:0] in_syn_weight;
  logic [15:0] in_syn_delay;
  logic [4:0]  in_syn_count;

  assign in_cmd        = cmd_t'(s_axis_tuser[1:0]);
  assign in_neuron     = s_axis_tdata[7:0];
  assign in_slot       = s_axis_tdata[11:8];
  assign in_time       = s_axis_tdata[43:12];
  assign in_value      = s_axis_tdata[75:44];
  assign in_syn_target = s_axis_tdata[83:76];
  assign in_syn_weight = s_axis_tdata[99:84];
  assign in_syn_delay  = s_axis_tdata[115:100];
  assign in_syn_count  = s_axis_tdata[120:116];

  logic [NIW+7:0] n_ext;
  logic [SIW+3:0] slot_ext;
  logic [NIW-1:0] in_addr;
  logic [SIW-1:0] in_slot_idx;
  logic           in_ok;
  logic           slot_ok;
  logic [CW-1:0]  cnt_load;

  assign n_ext       = (NIW + 8)'(in_neuron);
  assign slot_ext    = (SIW + 4)'(in_slot);
  assign in_addr     = n_ext[NIW-1:0];
  assign in_slot_idx = slot_ext[SIW-1:0];
  assign in_ok       = 32'(in_neuron) < 32'(NEURONS);
  assign slot_ok     = 32'(in_slot) < 32'(MAX_SYNAPSES);
  assign cnt_load    = (32'(in_syn_count) > 32'(MAX_SYNAPSES)) ? CW'(MAX_SYNAPSES)
                                                               : CW'(in_syn_count);

  state_t      state;
  logic        in_acc;
  logic [NIW-1:0] clr_idx;
  logic [31:0] leak_rate;

  // working registers
  logic [NIW-1:0] addr_r;
  logic [31:0]    t_r;
  logic [31:0]    val_r;
  logic [31:0]    chg;
  logic [SIW-1:0] k;
  logic [CW-1:0]  cnt_r;

  // memories: neuron state {last_update, charge}, synapse count, threshold, synapses
  logic [63:0]   nst_mem [NEURONS];
  logic [CW-1:0] cnt_mem [NEURONS];
  logic [31:0]   thr_mem [NEURONS];
  logic [39:0]   syn_mem [SYN_DEPTH];

  logic [63:0]   nst_rd;
  logic [CW-1:0] cnt_rd;
  logic [31:0]   thr_rd;
  logic [39:0]   syn_rd;   // {delay, weight, target}

  logic [NIW-1:0] nst_waddr;
  logic [63:0]    nst_wdata;
  logic           nst_we;
  logic           fire;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  logic [32:0] sum;
  logic [CW-1:0] k_plus1;
  logic        spike_last;
  spike_t      spike;
  logic        out_can_load;
  logic        out_load;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign fire = !(chg < thr_rd);
  assign sum  = {1'b0, chg} + {1'b0, val_r};

  assign k_plus1    = CW'(k) + CW'(1);
  assign spike_last = (k_plus1 == cnt_r);

  assign mul_a = (state == ST_MUL) ? (t_r - nst_rd[63:32]) : thr_rd;
  assign mul_b = (state == ST_MUL) ? leak_rate : {16'b0, syn_rd[23:8]};

  lifu_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign spike.target  = syn_rd[7:0];
  assign spike.charge  = mul_p[47:16];
  assign spike.time_tk = t_r + 32'(syn_rd[39:24]);
  assign spike.last    = spike_last;
  assign out_load      = (state == ST_SOUT);

  lifu_out u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (out_load),
    .spike         (spike),
    .can_load      (out_can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // neuron state write port: clearing sweep or end of an event
  always_comb begin
    nst_we    = 1'b0;
    nst_waddr = addr_r;
    nst_wdata = {t_r, fire ? 32'd0 : chg};
    if (state == ST_CLEAR) begin
      nst_we    = 1'b1;
      nst_waddr = clr_idx;
      nst_wdata = '0;
    end else if (state == ST_CMP) begin
      nst_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (nst_we) begin
      nst_mem[nst_waddr] <= nst_wdata;
    end
    if (state == ST_CLEAR) begin
      cnt_mem[clr_idx] <= '0;
    end else if (in_acc && in_ok && in_cmd == CMD_LOAD_CNT) begin
      cnt_mem[in_addr] <= cnt_load;
    end
    if (in_acc && in_ok && in_cmd == CMD_LOAD_THR) begin
      thr_mem[in_addr] <= in_value;
    end
    if (in_acc && in_ok && slot_ok && in_cmd == CMD_LOAD_SYN) begin
      syn_mem[{in_addr, in_slot_idx}] <= {in_syn_delay, in_syn_weight, in_syn_target};
    end
    // hold read data for the whole event
    if (state == ST_IDLE) begin
      nst_rd <= nst_mem[in_addr];
      cnt_rd <= cnt_mem[in_addr];
      thr_rd <= thr_mem[in_addr];
    end
    if (state == ST_SRD) begin
      syn_rd <= syn_mem[{addr_r, k}];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      leak_rate <= LEAK_RESET;
    end else begin
      if (cfg_wr_en) begin
        leak_rate <= cfg_wr_data;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + NIW'(1);
          if (clr_idx == NIW'(NEURONS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc && in_ok && in_cmd == CMD_SPIKE) begin
            state <= ST_MUL;
          end
        end
        ST_MUL:   state <= ST_DECAY;
        ST_DECAY: state <= ST_ADD;
        ST_ADD:   state <= ST_CMP;
        ST_CMP: begin
          if (fire && cnt_rd != '0) begin
            state <= ST_SRD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_SRD:  state <= ST_SMUL;
        ST_SMUL: state <= ST_SOUT;
        ST_SOUT: begin
          if (out_can_load) begin
            state <= spike_last ? ST_IDLE : ST_SRD;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      addr_r <= in_addr;
      t_r    <= in_time;
      val_r  <= in_value;
    end
    if (state == ST_DECAY) begin
      chg <= (mul_p >= {32'd0, nst_rd[31:0]}) ? 32'd0 : (nst_rd[31:0] - mul_p[31:0]);
    end else if (state == ST_ADD) begin
      chg <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end
    if (state == ST_CMP) begin
      k     <= '0;
      cnt_r <= cnt_rd;
    end else if (state == ST_SOUT && out_can_load) begin
      k <= k + SIW'(1);
    end
  end
endmodule

>>> design/lifu_mul.sv
// Shared 32x32 multiplier with a registered product.
module lifu_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);
  always_ff @(posedge clk) begin
    p <= 64'(a) * 64'(b);
  end
endmodule

>>> design/lifu_out.sv
// Output register for emitted spike beats.
module lifu_out (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  lifu_pkg::spike_t                  spike,
  output logic                              can_load,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [lifu_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast
);
  import lifu_pkg::*;

  spike_t held;

  assign can_load = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (can_load) begin
      m_axis_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      held <= spike;
    end
  end

  assign m_axis_tdata = {held.time_tk, held.charge, held.target};
  assign m_axis_tlast = held.last;
endmodule

>>> tb/lif_neuron_event_update_unit_tb.sv
// Self-checking testbench for the LIF neuron event update unit, with a built-in neuron predictor.
module lif_neuron_event_update_unit_tb;
  import lifu_pkg::*;

  localparam int NRN   = NEURONS_DEF;
  localparam int SLOTS = MAX_SYNAPSES_DEF;

  typedef struct {
    cmd_t        cmd;
    logic [7:0]  neuron;
    logic [3:0]  slot;
    logic [31:0] event_time;
    logic [31:0] value;
    logic [7:0]  syn_target;
    logic [15:0] syn_weight;
    logic [15:0] syn_delay;
    logic [4:0]  syn_count;
  } beat_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [31:0]            cfg_wr_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic [IN_USER_W-1:0]   s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                   m_axis_tlast;

  lif_neuron_event_update_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk = ~clk;

  // Predicted neuron state
  logic [31:0] rate_q;
  logic [31:0] mem_charge [NRN];
  logic [31:0] mem_stamp  [NRN];
  logic [31:0] mem_thr    [NRN];
  logic [4:0]  mem_cnt    [NRN];
  logic [7:0]  mem_tgt    [NRN*SLOTS];
  logic [15:0] mem_wt     [NRN*SLOTS];
  logic [15:0] mem_dly    [NRN*SLOTS];
  int          fires_total;

  beat_t  beats_todo [$];
  spike_t spikes_due [$];
  beat_t  held;
  beat_t  staged;
  spike_t want;

  int tx_idle_pct = 18;
  int rx_idle_pct = 68;
  int beats_in    = 0;
  int spikes_seen = 0;
  int errors      = 0;
  int stall_left  = 0;
  bit long_stall_done = 1'b0;

  // What the stimulus side knows has been written, so no unwritten entry is ever read
  bit        gen_thr_ok  [NRN];
  bit [31:0] gen_thr_val [NRN];
  bit [15:0] gen_slots   [NRN];
  logic [31:0] gen_time = '0;
  logic [7:0]  pool [6];

  task automatic integrate_beat(input beat_t b);
    logic [31:0] gone, c;
    logic [63:0] loss, sum, prod;
    logic [11:0] idx;
    spike_t sp;
    case (b.cmd)
      CMD_LOAD_THR: mem_thr[b.neuron] = b.value;
      CMD_LOAD_CNT: mem_cnt[b.neuron] = (b.syn_count > SLOTS) ? 5'(SLOTS) : b.syn_count;
      CMD_LOAD_SYN: begin
        idx = {b.neuron, b.slot};
        mem_tgt[idx] = b.syn_target;
        mem_wt[idx]  = b.syn_weight;
        mem_dly[idx] = b.syn_delay;
      end
      CMD_SPIKE: begin
        gone = b.event_time - mem_stamp[b.neuron];
        loss = 64'(gone) * 64'(rate_q);
        c = mem_charge[b.neuron];
        c = (loss >= 64'(c)) ? 32'd0 : c - loss[31:0];
        sum = 64'(c) + 64'(b.value);
        c = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        mem_stamp[b.neuron] = b.event_time;
        if (c < mem_thr[b.neuron]) begin
          mem_charge[b.neuron] = c;
        end else begin
          fires_total++;
          mem_charge[b.neuron] = '0;
          for (int k = 0; k < mem_cnt[b.neuron]; k++) begin
            idx = {b.neuron, k[3:0]};
            prod = 64'(mem_thr[b.neuron]) * 64'(mem_wt[idx]);
            sp.target  = mem_tgt[idx];
            sp.charge  = prod[47:16];
            sp.time_tk = b.event_time + 32'(mem_dly[idx]);
            sp.last    = (k + 1 == mem_cnt[b.neuron]);
            spikes_due.insert(spikes_due.size(), sp);
          end
        end
      end
    endcase
  endtask

  // Driver: offer pending beats, predict each one at acceptance
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      fires_total = 0;
      for (int i = 0; i < NRN; i++) begin
        mem_charge[i] = '0;
        mem_stamp[i]  = '0;
        mem_cnt[i]    = '0;
      end
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        integrate_beat(held);
        beats_in <= beats_in + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (beats_todo.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          staged = beats_todo.pop_front();
          held <= staged;
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= staged.cmd;
          s_axis_tdata <= {7'd0, staged.syn_count, staged.syn_delay, staged.syn_weight,
                           staged.syn_target, staged.value, staged.event_time,
                           staged.slot, staged.neuron};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off to fill the unit
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (!long_stall_done && spikes_seen >= 40) begin
      m_axis_tready <= 1'b0;
      stall_left <= 299;
      long_stall_done <= 1'b1;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Monitor: compare every spike beat against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      spikes_seen <= spikes_seen + 1;
      if (spikes_due.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10)
          $display("spike beat %0d with nothing predicted: data %h last %b",
                   spikes_seen, m_axis_tdata, m_axis_tlast);
      end else begin
        want = spikes_due.pop_front();
        if (m_axis_tdata[7:0] !== want.target || m_axis_tdata[39:8] !== want.charge ||
            m_axis_tdata[71:40] !== want.time_tk || m_axis_tlast !== want.last) begin
          errors <= errors + 1;
          if (errors < 10)
            $display("spike beat %0d: expected tgt %h chg %h at %h last %b, got %h %h %h %b",
                     spikes_seen, want.target, want.charge, want.time_tk, want.last,
                     m_axis_tdata[7:0], m_axis_tdata[39:8], m_axis_tdata[71:40],
                     m_axis_tlast);
        end
      end
    end
  end

  function automatic beat_t rand_beat(cmd_t cmd, logic [7:0] n);
    beat_t b;
    b.cmd        = cmd;
    b.neuron     = n;
    b.slot       = 4'($urandom);
    b.event_time = $urandom;
    b.value      = $urandom;
    b.syn_target = 8'($urandom);
    b.syn_weight = 16'($urandom);
    b.syn_delay  = 16'($urandom);
    b.syn_count  = 5'($urandom);
    return b;
  endfunction

  function automatic int syn_prefix(logic [7:0] n);
    int p = 0;
    while (p < SLOTS && gen_slots[n][p]) p++;
    return p;
  endfunction

  task automatic put_thr(logic [7:0] n, logic [31:0] v);
    beat_t b = rand_beat(CMD_LOAD_THR, n);
    b.value = v;
    gen_thr_ok[n] = 1'b1;
    gen_thr_val[n] = v;
    beats_todo.insert(beats_todo.size(), b);
  endtask

  task automatic put_syn(logic [7:0] n, logic [3:0] s, logic [7:0] tgt,
                         logic [15:0] w, logic [15:0] d);
    beat_t b = rand_beat(CMD_LOAD_SYN, n);
    b.slot = s;
    b.syn_target = tgt;
    b.syn_weight = w;
    b.syn_delay = d;
    gen_slots[n][s] = 1'b1;
    beats_todo.insert(beats_todo.size(), b);
  endtask

  task automatic put_cnt(logic [7:0] n, logic [4:0] c);
    beat_t b = rand_beat(CMD_LOAD_CNT, n);
    b.syn_count = c;
    beats_todo.insert(beats_todo.size(), b);
  endtask

  task automatic put_spike(logic [7:0] n, logic [31:0] t, logic [31:0] v);
    beat_t b = rand_beat(CMD_SPIKE, n);
    b.event_time = t;
    b.value = v;
    beats_todo.insert(beats_todo.size(), b);
  endtask

  function automatic logic [31:0] pick_thr();
    int r = $urandom_range(99);
    if (r < 85) return $urandom_range(32'h14_0000, 32'h8000);
    if (r < 95) return $urandom;
    return '0;
  endfunction

  task automatic random_beats(int total);
    logic [7:0]  n;
    logic [31:0] v;
    int r, p;
    repeat (total) begin
      n = ($urandom_range(99) < 75) ? pool[$urandom_range(5)] : 8'($urandom_range(255));
      r = $urandom_range(99);
      if (r < 62 && gen_thr_ok[n]) begin
        p = $urandom_range(99);
        if (p < 40)      gen_time = gen_time;
        else if (p < 80) gen_time = gen_time + $urandom_range(4, 1);
        else if (p < 95) gen_time = gen_time + $urandom_range(65535);
        else             gen_time = $urandom;
        p = $urandom_range(99);
        if (p < 8)       v = 32'hFFFF_FFFF;
        else if (p < 14) v = $urandom;
        else if (p < 18) v = '0;
        else             v = 32'(64'($urandom) % (64'(gen_thr_val[n]) + 64'd1));
        put_spike(n, gen_time, v);
      end else if (r < 75) begin
        put_thr(n, pick_thr());
      end else if (r < 90) begin
        p = syn_prefix(n);
        put_syn(n, (p < SLOTS && $urandom_range(9) < 7) ? 4'(p) : 4'($urandom),
                8'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        p = syn_prefix(n);
        if (p == SLOTS && $urandom_range(3) == 0) put_cnt(n, 5'($urandom_range(31, 17)));
        else put_cnt(n, 5'($urandom_range(p)));
      end
    end
  endtask

  task automatic set_rate(logic [31:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    rate_q = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Hold the sender until every predicted spike is out, then let the pipeline settle
  task automatic wait_idle();
    do @(negedge clk);
    while (beats_todo.size() != 0 || s_axis_tvalid || spikes_due.size() != 0);
    repeat (60) @(negedge clk);
  endtask

  initial begin
    int k;
    rate_q = LEAK_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: extremes, every command, saturation, wrap, backward time, equality
    put_thr(8'd0, 32'h3_0000);
    put_syn(8'd0, 4'd0, 8'hFF, 16'hFFFF, 16'h0000);
    put_syn(8'd0, 4'd1, 8'h00, 16'h0000, 16'hFFFF);
    put_syn(8'd0, 4'd2, 8'hAA, 16'h8000, 16'd7);
    put_cnt(8'd0, 5'd3);
    put_spike(8'd0, 32'd10, 32'h2_0000);
    put_spike(8'd0, 32'd11, 32'hFFFF_FFFF);
    put_thr(8'd255, 32'hFFFF_FFFF);
    put_cnt(8'd255, 5'd0);
    put_spike(8'd255, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    put_thr(8'd1, 32'd0);
    put_syn(8'd1, 4'd0, 8'd1, 16'hFFFF, 16'hFFFF);
    put_cnt(8'd1, 5'd1);
    put_spike(8'd1, 32'hFFFF_FFF8, 32'd0);
    put_spike(8'd0, 32'd5, 32'h1_0000);
    put_spike(8'd0, 32'd5, 32'h2_0000);
    put_syn(8'd0, 4'd1, 8'h55, 16'h1234, 16'h8000);
    put_cnt(8'd0, 5'd2);
    put_spike(8'd0, 32'd7, 32'h3_0000);
    gen_time = 32'd7;
    wait_idle();

    // Well-formed neuron setups, one with a full synapse table and an oversized count
    set_rate(32'd0);
    pool[0] = 8'd0;
    pool[1] = 8'd255;
    for (int i = 2; i < 6; i++) pool[i] = 8'($urandom_range(254, 2));
    for (int i = 0; i < 6; i++) begin
      put_thr(pool[i], pick_thr());
      k = (pool[i] == 8'd255) ? SLOTS : $urandom_range(5, 1);
      for (int s = 0; s < k; s++)
        put_syn(pool[i], 4'(s), 8'($urandom), 16'($urandom), 16'($urandom));
      put_cnt(pool[i], (k == SLOTS) ? 5'd31 : 5'(k));
    end
    random_beats(110);
    wait_idle();

    tx_idle_pct = 68;
    rx_idle_pct = 18;
    set_rate(32'hFFFF_FFFF);
    random_beats(150);
    wait_idle();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_rate($urandom_range(32'h2_0000, 32'h100));
    random_beats(160);
    wait_idle();

    $display("run covered %0d input beats across four decay rates, %0d firings",
             beats_in, fires_total);
    $display("%0d spike beats checked, %0d mismatches", spikes_seen, errors);
    if (errors == 0 && spikes_due.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> sim.f
design/lifu_pkg.sv
design/lifu_mul.sv
design/lifu_out.sv
design/lif_neuron_event_update_unit.sv
tb/lif_neuron_event_update_unit_tb.sv
